[src/b2da_pkg.sv]
`timescale 1ns / 1ps

package b2da_pkg;

    localparam int MAX_DIGITS  = 10;
    localparam int VALUE_W     = 32;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 6;
    localparam int OUT_TDATA_W = 8;
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W       = $clog2(MAX_DIGITS);

    // Reciprocal of ten for a 32-bit dividend: q = (v * RECIP_TEN) >> RECIP_SHIFT.
    localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // One converted value: digits stored least significant first.
    typedef struct packed {
        logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits;
        logic [CNT_W-1:0]                   count;
    } digit_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } front_state_t;

endpackage

[src/binary_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// The front registers a value at its input transfer, divides it by ten once per digit and
// pushes the finished record into the queue; the back loads its digits into the output register.
// The front takes a new value only after it has pushed the record of the previous one; the
// back emits one digit a cycle while the queue holds a record and m_tready is high.
// Reset: rst_n is asynchronous and active low; it empties the queue and the output stage.

module binary_to_decimal_ascii
    import b2da_pkg::*;
#(
    // Number of converted values buffered between front and back (at least 2).
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input stream. s_tdata fields from bit 0 up: value[31:0].
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [VALUE_W-1:0]     s_tdata,
    // Output stream. m_tdata fields from bit 0 up: digit_char[5:0], then two zero bits.
    // m_tlast carries last_digit and marks the least significant digit of a value.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast
);

    // The front takes one value per transfer and divides it by ten once per
    // cycle, collecting the remainders as digits, least significant first.
    // A finished value travels through the queue as one record holding all
    // of its digits and the digit count, so the front can start the next
    // value while the back is still sending characters.
    queue_status_t q_stat;
    digit_rec_t    push_rec;
    digit_rec_t    head_rec;
    logic          push;
    logic          pop;

    b2da_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_stat   (q_stat),
        .push     (push),
        .push_rec (push_rec)
    );

    b2da_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .stat     (q_stat)
    );

    // The back walks the head record from its most significant digit down,
    // loading one ASCII character per cycle into the output register while it is free, and
    // releases the record when the last digit has been loaded.
    b2da_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_rec (head_rec),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[src/b2da_front.sv]
`timescale 1ns / 1ps

module b2da_front
    import b2da_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,
    input  queue_status_t      q_stat,
    output logic               push,
    output digit_rec_t         push_rec
);

    front_state_t state_reg, state_next;

    logic [VALUE_W-1:0]                 value_reg, value_next;
    logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_reg, digits_next, digits_upd;
    logic [CNT_W-1:0]                   cnt_reg, cnt_next;

    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   quot;
    logic [VALUE_W-1:0]   quot_x10;
    logic [DIGIT_W-1:0]   rem;
    logic                 conv_done;

    // Divide by ten through the reciprocal; the remainder needs only the low bits.
    assign prod      = {{VALUE_W{1'b0}}, value_reg} * {{VALUE_W{1'b0}}, RECIP_TEN};
    assign quot      = {{RECIP_SHIFT - VALUE_W{1'b0}}, prod[2*VALUE_W-1:RECIP_SHIFT]};
    assign quot_x10  = {quot[VALUE_W-4:0], 3'b000} + {quot[VALUE_W-2:0], 1'b0};
    assign rem       = value_reg[DIGIT_W-1:0] - quot_x10[DIGIT_W-1:0];
    assign conv_done = (quot == '0) || (cnt_reg == CNT_W'(MAX_DIGITS - 1));

    always_comb
    begin
        digits_upd = digits_reg;
        digits_upd[cnt_reg[IDX_W-1:0]] = rem;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = F_CONV;
                end
            end
            F_CONV:
            begin
                if (conv_done)
                begin
                    state_next = q_stat.full ? F_PUSH : F_IDLE;
                end
            end
            F_PUSH:
            begin
                if (!q_stat.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        push     = 1'b0;
        push_rec = '{digits: digits_reg, count: cnt_reg};
        unique case (state_reg)
            F_IDLE:
            begin
                s_tready = 1'b1;
            end
            F_CONV:
            begin
                push     = conv_done && !q_stat.full;
                push_rec = '{digits: digits_upd, count: cnt_reg + CNT_W'(1)};
            end
            F_PUSH:
            begin
                push = !q_stat.full;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        value_next  = value_reg;
        digits_next = digits_reg;
        cnt_next    = cnt_reg;
        if (state_reg == F_IDLE && s_tvalid)
        begin
            value_next = s_tdata;
            cnt_next   = '0;
        end
        else if (state_reg == F_CONV)
        begin
            value_next  = quot;
            digits_next = digits_upd;
            cnt_next    = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        digits_reg <= digits_next;
        cnt_reg    <= cnt_next;
    end

endmodule

[src/b2da_queue.sv]
`timescale 1ns / 1ps

module b2da_queue
    import b2da_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  digit_rec_t    push_rec,
    input  logic          pop,
    output digit_rec_t    head_rec,
    output queue_status_t stat
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    digit_rec_t        entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign stat.full  = (fill_reg == FILL_W'(DEPTH));
    assign stat.empty = (fill_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_rec   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

[src/b2da_back.sv]
`timescale 1ns / 1ps

module b2da_back
    import b2da_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  digit_rec_t             head_rec,
    input  queue_status_t          q_stat,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast
);

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] m_char_reg, m_char_next;
    logic              m_last_reg, m_last_next;

    logic              load;
    logic              issue;
    logic [CNT_W-1:0]  top_pos;
    logic [CNT_W-1:0]  pos_full;
    logic [IDX_W-1:0]  pos;
    logic              is_last;

    // Digits sit least significant first, so walk them from the top down.
    assign load     = !m_valid_reg || m_tready;
    assign issue    = load && !q_stat.empty;
    assign top_pos  = head_rec.count - CNT_W'(1);
    assign pos_full = top_pos - CNT_W'(idx_reg);
    assign pos      = pos_full[IDX_W-1:0];
    assign is_last  = (CNT_W'(idx_reg) == top_pos);
    assign pop      = issue && is_last;

    always_comb
    begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        if (load)
        begin
            m_valid_next = issue;
        end
        if (issue)
        begin
            m_char_next = ASCII_ZERO + {{(CHAR_W - DIGIT_W){1'b0}}, head_rec.digits[pos]};
            m_last_next = is_last;
            idx_next    = is_last ? '0 : idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - CHAR_W){1'b0}}, m_char_reg};
    assign m_tlast  = m_last_reg;

endmodule

[src/b2da_checker.sv]
`timescale 1ns / 1ps

module b2da_checker
    import b2da_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tlast
);

    logic             start_reg;
    logic [CNT_W-1:0] run_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= 1'b1;
            run_cnt_reg <= '0;
        end
        else if (m_tvalid && m_tready)
        begin
            start_reg   <= m_tlast;
            run_cnt_reg <= m_tlast ? '0 : run_cnt_reg + CNT_W'(1);
        end
    end

    // Every character is an ASCII decimal digit with the padding bits clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata >= OUT_TDATA_W'(48)) && (m_tdata <= OUT_TDATA_W'(57)))
        else $error("output character is not a decimal digit");

    // A run of several digits never opens with a leading zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && start_reg && !m_tlast) |-> (m_tdata != OUT_TDATA_W'(48)))
        else $error("leading zero in a multi-digit run");

    // No run is longer than the widest 32-bit value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (run_cnt_reg < CNT_W'(MAX_DIGITS)))
        else $error("digit run exceeds the maximum length");

    // A stalled output transfer keeps its character and marker.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled output changed");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (.*);

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import b2da_pkg::*;

    // Cycles without any transfer on either side before the run is declared hung.
    // The longest legal quiet stretch is the deliberate receiver hold-off below.
    localparam int IDLE_LIMIT    = 2000;
    // Receiver hold-off, long enough to fill the block and stall its input.
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 120;
    localparam int RANDOM_VALUES = 260;
    // Quiet cycles allowed after the last expected digit has arrived.
    localparam int DRAIN_CYCLES  = 40;

    // One expected output character with its end-of-number mark.
    typedef struct {
        logic [CHAR_W-1:0] ch_code;
        logic              last;
    } digit_item_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [VALUE_W-1:0]     s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    // Values waiting to be offered, and the characters they must turn into.
    logic [VALUE_W-1:0] value_queue[$];
    digit_item_t        digit_queue[$];

    int          mismatch_count = 0;
    int          values_sent = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    logic        hold_active;
    logic [15:0] cycle_count = '0;
    logic        calm;
    int          idle_cycles = 0;

    binary_to_decimal_ascii i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    // While cycle_count[7:6] is zero, a quarter of the time, neither side picks new gaps, so that
    // back-to-back transfers are covered as well as gaps on every phase.
    assign calm        = (cycle_count[7:6] == 2'b00);
    assign hold_active = (hold_left != 0);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 16'd1;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    // Works out the decimal characters of one value and queues them in display
    // order. The digits come out least significant first from repeated division,
    // so they are collected and then queued in reverse. Zero yields a single '0'.
    task automatic push_decimal_digits(input logic [VALUE_W-1:0] value);
        logic [3:0]         rev[MAX_DIGITS];
        logic [VALUE_W-1:0] rem;
        int                 n;
        digit_item_t        item;
        rem = value;
        n = 0;
        do
        begin
            rev[n] = 4'(rem % 10);
            rem = rem / 10;
            n++;
        end
        while (rem != 0 && n < MAX_DIGITS);
        for (int k = n - 1; k >= 0; k--)
        begin
            item.ch_code = ASCII_ZERO + CHAR_W'(rev[k]);
            item.last    = (k == 0);
            digit_queue.push_back(item);
        end
    endtask

    // Random value with a chosen number of decimal digits, so that every run
    // length from one to ten characters shows up often.
    function automatic logic [VALUE_W-1:0] value_with_digits(input int ndig);
        longint unsigned lo;
        longint unsigned hi;
        lo = 1;
        for (int k = 1; k < ndig; k++)
            lo = lo * 10;
        hi = (ndig == MAX_DIGITS) ? 64'hFFFF_FFFF : lo * 10 - 1;
        if (ndig == 1)
            lo = 0;
        return $urandom_range(32'(hi), 32'(lo));
    endfunction

    // Input driver. An offered value is held until its transfer; the expected
    // characters are predicted at the edge where the transfer happens. While
    // the receiver holds off, the driver keeps offering with no gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                push_decimal_digits(s_tdata);
                void'(value_queue.pop_front());
                values_sent <= values_sent + 1;
            end
            if (s_tvalid && !s_tready)
            begin
                // Keep the current value on the bus until it is taken.
            end
            else if (send_gap != 0)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (value_queue.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= value_queue[0];
                if (!calm && !hold_active)
                    send_gap <= pick_gap();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver ready. Once enough values have gone in, the receiver holds off
    // for a long stretch so that the block's buffer fills and s_tready drops.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            recv_gap  <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && values_sent >= HOLD_AFTER)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= (hold_left == 1);
        end
        else if (recv_gap != 0)
        begin
            recv_gap <= recv_gap - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!calm)
                recv_gap <= pick_gap();
        end
    end

    // Output monitor. Each character transfer is matched against the oldest
    // expected character; the two pad bits above the character must be zero.
    always @(posedge clk)
    begin : output_check
        digit_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (digit_queue.size() == 0)
            begin
                report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                          m_tdata, m_tlast));
            end
            else
            begin
                want = digit_queue.pop_front();
                if (m_tdata != {{(OUT_TDATA_W - CHAR_W){1'b0}}, want.ch_code})
                    report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                              m_tdata, want.ch_code));
                if (m_tlast != want.last)
                    report_mismatch($sformatf("last mark %0b, expected %0b on 0x%02h",
                                              m_tlast, want.last, want.ch_code));
            end
        end
    end

    // Watchdog: counts cycles in which neither side completes a transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout after %0d cycles without a transfer", idle_cycles);
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        // Directed values: zero, single digits, every power-of-ten boundary,
        // the largest values and alternating bit patterns.
        value_queue.push_back(32'd0);
        value_queue.push_back(32'd1);
        value_queue.push_back(32'd9);
        value_queue.push_back(32'd10);
        value_queue.push_back(32'd99);
        value_queue.push_back(32'd100);
        value_queue.push_back(32'd999);
        value_queue.push_back(32'd1000);
        value_queue.push_back(32'd9999);
        value_queue.push_back(32'd10000);
        value_queue.push_back(32'd99999);
        value_queue.push_back(32'd100000);
        value_queue.push_back(32'd999999);
        value_queue.push_back(32'd1000000);
        value_queue.push_back(32'd9999999);
        value_queue.push_back(32'd10000000);
        value_queue.push_back(32'd99999999);
        value_queue.push_back(32'd100000000);
        value_queue.push_back(32'd999999999);
        value_queue.push_back(32'd1000000000);
        value_queue.push_back(32'd2147483647);
        value_queue.push_back(32'd2147483648);
        value_queue.push_back(32'hFFFF_FFFF);
        value_queue.push_back(32'hAAAA_AAAA);
        value_queue.push_back(32'h5555_5555);

        // Random part: mostly values of a chosen digit count, some raw 32-bit
        // words so every input bit toggles, and an occasional zero.
        for (int i = 0; i < RANDOM_VALUES; i++)
        begin
            case ($urandom_range(9, 0))
                0:       value_queue.push_back($urandom());
                1:       value_queue.push_back($urandom_range(1, 0) ? $urandom() : 32'd0);
                default: value_queue.push_back(value_with_digits($urandom_range(MAX_DIGITS, 1)));
            endcase
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every value has been taken and every character has arrived,
        // then give any stray output time to show up.
        @(negedge clk);
        while (value_queue.size() != 0 || s_tvalid || digit_queue.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (digit_queue.size() != 0)
            report_mismatch($sformatf("%0d expected characters never arrived",
                                      digit_queue.size()));

        if (mismatch_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

[sim.f]
src/b2da_pkg.sv
src/b2da_front.sv
src/b2da_queue.sv
src/b2da_back.sv
src/binary_to_decimal_ascii.sv
src/b2da_checker.sv
bench/testbench.sv
